// ----- rtl/core/pkcr_pkg.sv -----
// Package for the PS/2 keyboard command responder.
// Holds host command codes, reply codes, mode and reply-plan types, and the
// reply byte lookup. No dependencies.
package pkcr_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [7:0] CMD_RESET     = 8'hFF;
   localparam logic [7:0] CMD_RESEND    = 8'hFE;
   localparam logic [7:0] CMD_DEFAULTS  = 8'hF6;
   localparam logic [7:0] CMD_SCAN_OFF  = 8'hF5;
   localparam logic [7:0] CMD_SCAN_ON   = 8'hF4;
   localparam logic [7:0] CMD_TYPEMATIC = 8'hF3;
   localparam logic [7:0] CMD_IDENTIFY  = 8'hF2;
   localparam logic [7:0] CMD_SCANSET   = 8'hF0;
   localparam logic [7:0] CMD_ECHO      = 8'hEE;
   localparam logic [7:0] CMD_LEDS      = 8'hED;

   localparam logic [7:0] REPLY_ACK    = 8'hFA;
   localparam logic [7:0] REPLY_NAK    = 8'hFE;
   localparam logic [7:0] REPLY_PASSED = 8'hAA;
   localparam logic [7:0] REPLY_ECHO   = 8'hEE;
   localparam logic [7:0] ID_FIRST     = 8'hAB;
   localparam logic [7:0] ID_SECOND    = 8'h83;
   localparam logic [7:0] SET_NUMBER   = 8'h02;
   localparam logic [7:0] SET_QUERY    = 8'h00;

   typedef enum logic [1:0] {
      MODE_COMMAND   = 2'd0,
      MODE_LEDS      = 2'd1,
      MODE_TYPEMATIC = 2'd2,
      MODE_SCANSET   = 2'd3
   } mode_type;

   // What the back end has to send for one host byte.
   typedef enum logic [2:0] {
      RUN_ACK,
      RUN_NAK,
      RUN_ECHO,
      RUN_RESET,
      RUN_IDENT,
      RUN_SETNUM
   } run_type;

   typedef struct packed {
      run_type run;
      logic    scan;
   } plan_type;

   typedef struct packed {
      logic     valid;
      plan_type plan;
   } plan_beat_type;

   // Index of the final beat of a run.
   function automatic logic [1:0] run_last_idx(run_type run);
      logic [1:0] idx;
      idx = 2'd0;
      case (run)
         RUN_RESET, RUN_SETNUM: idx = 2'd1;
         RUN_IDENT:             idx = 2'd2;
         default:               idx = 2'd0;
      endcase
      return idx;
   endfunction

   function automatic logic [7:0] run_byte(run_type run, logic [1:0] idx);
      logic [7:0] b;
      b = REPLY_ACK;
      case (run)
         RUN_NAK:    b = REPLY_NAK;
         RUN_ECHO:   b = REPLY_ECHO;
         RUN_RESET:  b = (idx == 2'd0) ? REPLY_ACK : REPLY_PASSED;
         RUN_IDENT: begin
            case (idx)
               2'd0:    b = REPLY_ACK;
               2'd1:    b = ID_FIRST;
               default: b = ID_SECOND;
            endcase
         end
         RUN_SETNUM: b = (idx == 2'd0) ? REPLY_ACK : SET_NUMBER;
         default:    b = REPLY_ACK;
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/core/pkcr_front.sv -----
// Front end: accepts host bytes, tracks mode and scanning flag, and turns
// each byte into a reply plan. Depends on pkcr_pkg.
module pkcr_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic [7:0]             req_host_byte,
   input  logic                   queue_full,
   output pkcr_pkg::plan_beat_type plan_out
);
   import pkcr_pkg::*;

   mode_type mode_ff, mode_in;
   logic     scan_ff, scan_in;
   logic     accept;
   run_type  run;

   assign accept = req_push && !queue_full;

   always_comb begin
      mode_in = mode_ff;
      scan_in = scan_ff;
      run     = RUN_ACK;
      unique case (mode_ff)
         MODE_COMMAND: begin
            unique case (req_host_byte)
               CMD_RESET: begin
                  run     = RUN_RESET;
                  mode_in = MODE_COMMAND;
               end
               CMD_LEDS:      mode_in = MODE_LEDS;
               CMD_ECHO:      run = RUN_ECHO;
               CMD_SCANSET:   mode_in = MODE_SCANSET;
               CMD_TYPEMATIC: mode_in = MODE_TYPEMATIC;
               CMD_SCAN_OFF: begin
                  scan_in = 1'b0;
                  mode_in = MODE_COMMAND;
               end
               CMD_SCAN_ON:   scan_in = 1'b1;
               CMD_IDENTIFY:  run = RUN_IDENT;
               CMD_DEFAULTS:  mode_in = MODE_COMMAND;
               CMD_RESEND:    run = RUN_ACK;
               default:       run = RUN_NAK;
            endcase
         end
         MODE_SCANSET: begin
            if (req_host_byte == SET_QUERY) begin
               run = RUN_SETNUM;
            end else if (req_host_byte != SET_NUMBER) begin
               run = RUN_NAK;
            end
            mode_in = MODE_COMMAND;
         end
         default: mode_in = MODE_COMMAND;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_COMMAND;
         scan_ff <= 1'b1;
      end else if (accept) begin
         mode_ff <= mode_in;
         scan_ff <= scan_in;
      end
   end

   assign plan_out.valid     = accept;
   assign plan_out.plan.run  = run;
   assign plan_out.plan.scan = scan_in;

endmodule

// ----- rtl/core/pkcr_queue.sv -----
// Short plan queue between front and back end.
// Depends on pkcr_pkg.
module pkcr_queue #(
   parameter int unsigned Depth = pkcr_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pkcr_pkg::plan_beat_type plan_in,
   output logic                    full,
   output pkcr_pkg::plan_beat_type plan_out,
   input  logic                    pop
);
   import pkcr_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   plan_type          slot_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign do_push = plan_in.valid && !full;
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= plan_in.plan;
      end
   end

   assign plan_out.valid = (count_ff != '0);
   assign plan_out.plan  = slot_ff[rd_ptr_ff];

endmodule

// ----- rtl/core/pkcr_back.sv -----
// Back end: plays each queued plan out as one to three reply beats into
// the output register. Depends on pkcr_pkg.
module pkcr_back (
   input  logic                    clock,
   input  logic                    reset,
   input  pkcr_pkg::plan_beat_type plan_in,
   output logic                    plan_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [7:0]              rsp_reply_byte,
   output logic                    rsp_last_of_reply,
   output logic                    rsp_scanning_on
);
   import pkcr_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       scan_ff;
   logic [1:0] beat_ff, beat_in;
   logic       load;
   logic       is_last;

   assign load    = plan_in.valid && (!out_valid_ff || rsp_pop);
   assign is_last = (beat_ff == run_last_idx(plan_in.plan.run));

   // Drop the plan from the queue once its final beat is loaded.
   assign plan_pop = load && is_last;

   always_comb begin
      beat_in      = beat_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
         beat_in      = is_last ? 2'd0 : beat_ff + 2'd1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         beat_ff      <= 2'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         beat_ff      <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= run_byte(plan_in.plan.run, beat_ff);
         last_ff <= is_last;
         scan_ff <= plan_in.plan.scan;
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_reply_byte    = byte_ff;
   assign rsp_last_of_reply = last_ff;
   assign rsp_scanning_on   = scan_ff;

endmodule

// ----- rtl/core/ps2_keyboard_command_responder_top.sv -----
// Top level of the PS/2 keyboard command responder (device side).
// Instantiates pkcr_front, pkcr_queue and pkcr_back; depends on pkcr_pkg.
//
// Usage:
//   Input channel: drive req_host_byte and raise req_push; the byte is taken
//   at a rising edge where req_push is high and req_full is low. Each byte is
//   a command or an argument, depending on the mode left by earlier bytes.
//   Result channel: while rsp_empty is low, the oldest reply beat is on
//   rsp_reply_byte, rsp_last_of_reply and rsp_scanning_on; raise rsp_pop to
//   take it. Each host byte yields one to three beats; rsp_last_of_reply marks
//   the final beat of a run, rsp_scanning_on shows the scanning flag after
//   that host byte.
//   Path: the plan of a host byte is written into the plan queue when the byte
//   is taken; its first beat is then loaded from the queue into the output register.
//   Throughput: the back end emits one beat per cycle while rsp_pop keeps the
//   output register free; identify yields three beats. The front end takes one byte
//   per cycle until the plan queue (QueueDepth entries) fills.
//   Stalls: holding rsp_pop low freezes the output register; the back end
//   then stops, the queue fills and req_full rises. Nothing is dropped.
//   Reset: synchronous, active high. Returns to command mode with scanning
//   enabled and empties the queue and output register.
module ps2_keyboard_command_responder_top #(
   parameter int unsigned QueueDepth = pkcr_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_host_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_reply_byte,
   output logic       rsp_last_of_reply,
   output logic       rsp_scanning_on
);
   import pkcr_pkg::*;

   plan_beat_type front_plan;
   plan_beat_type queue_plan;
   logic          queue_full;
   logic          plan_pop;

   assign req_full = queue_full;

   // Classify the host byte and advance mode and scanning flag.
   pkcr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_host_byte (req_host_byte),
      .queue_full    (queue_full),
      .plan_out      (front_plan)
   );

   // Hold plans until the back end can play them out.
   pkcr_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .plan_in  (front_plan),
      .full     (queue_full),
      .plan_out (queue_plan),
      .pop      (plan_pop)
   );

   // Emit reply beats one per cycle into the output register while rsp_pop keeps it free.
   pkcr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .plan_in           (queue_plan),
      .plan_pop          (plan_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_reply_byte    (rsp_reply_byte),
      .rsp_last_of_reply (rsp_last_of_reply),
      .rsp_scanning_on   (rsp_scanning_on)
   );

endmodule

// ----- verif/pkcr_reply_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the PS/2 keyboard command responder: watches both queue ports,
// predicts the reply beats of every accepted host byte and compares them in order.
// Depends on pkcr_pkg for command, reply and mode codes.
module pkcr_reply_checker
   import pkcr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [7:0] req_host_byte,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic [7:0] rsp_reply_byte,
   input  logic       rsp_last_of_reply,
   input  logic       rsp_scanning_on,
   output int         fail_count,
   output int         pending_count
);

   typedef struct {
      logic [7:0] reply_byte;
      logic       last_of_reply;
      logic       scanning_on;
   } reply_beat_type;

   reply_beat_type reply_queue [$];
   mode_type       kbd_mode;
   logic           kbd_scan;
   int             mismatches;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      mismatches    = 0;
      kbd_mode      = MODE_COMMAND;
      kbd_scan      = 1'b1;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
      mismatches = mismatches + 1;
   endtask

   // Advance the keyboard mode and queue the reply run for one host byte.
   task automatic predict_replies(input logic [7:0] host_byte);
      logic [7:0]     run_bytes [3];
      int             run_len;
      reply_beat_type beat;
      run_bytes[0] = REPLY_ACK;
      run_bytes[1] = 8'h00;
      run_bytes[2] = 8'h00;
      run_len = 1;
      case (kbd_mode)
         MODE_COMMAND: begin
            case (host_byte)
               CMD_RESET: begin
                  run_bytes[1] = REPLY_PASSED;
                  run_len = 2;
               end
               CMD_LEDS:      kbd_mode = MODE_LEDS;
               CMD_ECHO:      run_bytes[0] = REPLY_ECHO;
               CMD_SCANSET:   kbd_mode = MODE_SCANSET;
               CMD_TYPEMATIC: kbd_mode = MODE_TYPEMATIC;
               CMD_SCAN_OFF:  kbd_scan = 1'b0;
               CMD_SCAN_ON:   kbd_scan = 1'b1;
               CMD_IDENTIFY: begin
                  run_bytes[1] = ID_FIRST;
                  run_bytes[2] = ID_SECOND;
                  run_len = 3;
               end
               CMD_DEFAULTS, CMD_RESEND: ;
               default:       run_bytes[0] = REPLY_NAK;
            endcase
         end
         MODE_SCANSET: begin
            if (host_byte == SET_QUERY) begin
               run_bytes[1] = SET_NUMBER;
               run_len = 2;
            end else if (host_byte != SET_NUMBER) begin
               run_bytes[0] = REPLY_NAK;
            end
            kbd_mode = MODE_COMMAND;
         end
         default: kbd_mode = MODE_COMMAND;
      endcase
      for (int k = 0; k < run_len; k++) begin
         beat.reply_byte    = run_bytes[k];
         beat.last_of_reply = (k == run_len - 1);
         beat.scanning_on   = kbd_scan;
         reply_queue.push_back(beat);
      end
   endtask

   always @(posedge clock) begin
      reply_beat_type oldest;
      if (reset) begin
         kbd_mode = MODE_COMMAND;
         kbd_scan = 1'b1;
         reply_queue.delete();
      end else begin
         // Replies leave only after their byte is taken, so check before predicting.
         if (rsp_pop && !rsp_empty) begin
            if (reply_queue.size() == 0) begin
               report_mismatch("unexpected reply beat", int'(rsp_reply_byte), 0);
            end else begin
               oldest = reply_queue.pop_front();
               if (rsp_reply_byte !== oldest.reply_byte)
                  report_mismatch("reply_byte", int'(rsp_reply_byte),
                                  int'(oldest.reply_byte));
               if (rsp_last_of_reply !== oldest.last_of_reply)
                  report_mismatch("last_of_reply", int'(rsp_last_of_reply),
                                  int'(oldest.last_of_reply));
               if (rsp_scanning_on !== oldest.scanning_on)
                  report_mismatch("scanning_on", int'(rsp_scanning_on),
                                  int'(oldest.scanning_on));
            end
         end
         if (req_push && !req_full)
            predict_replies(req_host_byte);
      end
      pending_count <= reply_queue.size();
      fail_count    <= mismatches;
   end

endmodule

// ----- verif/ps2_keyboard_command_responder_top_test.sv -----
`timescale 1ns / 100ps
// Top of the PS/2 keyboard command responder test: clock, reset, host byte stimulus,
// reply popping and the verdict. Depends on pkcr_pkg and pkcr_reply_checker.
module ps2_keyboard_command_responder_top_test;
   import pkcr_pkg::*;

   localparam int CLOCK_HALF      = 10;
   localparam int RESET_CYCLES    = 8;
   localparam int MAX_GAP         = 17;
   localparam int PHASE_ITEMS     = 58;
   localparam int PHASE_COUNT     = 4;
   localparam int HOLD_OFF_CYCLES = 250;
   localparam int TAIL_CYCLES     = 40;
   localparam int LIMIT_CYCLES    = 400000;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_host_byte;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [7:0] rsp_reply_byte;
   logic       rsp_last_of_reply;
   logic       rsp_scanning_on;

   int fail_count;
   int pending_count;
   int cycle_count;

   // Idling style per side, switched between phases by the stimulus process.
   bit sender_idle_on;
   bit receiver_idle_on;
   // Set by the stimulus; the receiver picks it up and stalls for a long stretch.
   bit hold_off_request;

   ps2_keyboard_command_responder_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_host_byte     (req_host_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_reply_byte    (rsp_reply_byte),
      .rsp_last_of_reply (rsp_last_of_reply),
      .rsp_scanning_on   (rsp_scanning_on)
   );

   pkcr_reply_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_host_byte     (req_host_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_reply_byte    (rsp_reply_byte),
      .rsp_last_of_reply (rsp_last_of_reply),
      .rsp_scanning_on   (rsp_scanning_on),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   // Drive every input to a known value at time zero.
   initial begin
      reset            = 1'b1;
      req_push         = 1'b0;
      req_host_byte    = 8'h00;
      rsp_pop          = 1'b0;
      sender_idle_on   = 1'b1;
      receiver_idle_on = 1'b1;
      hold_off_request = 1'b0;
      cycle_count      = 0;
   end

   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int draw_gap(input bit idle_on);
      return idle_on ? int'($urandom_range(0, MAX_GAP)) : 0;
   endfunction

   // Offer one host byte and hold it until the block takes it. Push stays high
   // after the accepting edge so a zero gap on the next beat keeps the stream dense.
   task automatic offer_host_byte(input logic [7:0] host_byte);
      int gap;
      gap = draw_gap(sender_idle_on);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_host_byte <= host_byte;
      do @(posedge clock); while (req_full);
   endtask

   // Drop push, then hold the sender until every predicted reply beat has been popped.
   task automatic drain_replies();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Ordinary commands, so most random traffic lands on defined behavior.
   function automatic logic [7:0] pick_command();
      logic [7:0] cmd;
      case ($urandom_range(0, 6))
         0:       cmd = CMD_RESET;
         1:       cmd = CMD_RESEND;
         2:       cmd = CMD_DEFAULTS;
         3:       cmd = CMD_SCAN_OFF;
         4:       cmd = CMD_SCAN_ON;
         5:       cmd = CMD_IDENTIFY;
         default: cmd = CMD_ECHO;
      endcase
      return cmd;
   endfunction

   // Receiver: pop reply beats with random holds, plus the long hold-off on request.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            gap = HOLD_OFF_CYCLES;
         end else begin
            gap = draw_gap(receiver_idle_on);
         end
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   // Stimulus and verdict.
   initial begin
      logic [7:0] directed_bytes [$];
      int         items_in_phase;
      int         kind;
      logic [7:0] arg;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every command, unknown codes, each argument kind, the scancode
      // set query, the set-2 answer, a rejected set, a command code taken as an
      // argument, and reset leaving the scanning flag alone.
      directed_bytes = '{
         CMD_RESET, CMD_ECHO, CMD_IDENTIFY, CMD_SCAN_OFF, CMD_ECHO,
         CMD_RESET, CMD_ECHO, CMD_SCAN_ON, CMD_DEFAULTS, CMD_RESEND,
         8'h00, 8'h7F, 8'hEF,
         CMD_LEDS, 8'hFF,
         CMD_TYPEMATIC, 8'h00,
         CMD_SCANSET, SET_QUERY,
         CMD_SCANSET, SET_NUMBER,
         CMD_SCANSET, 8'h01,
         CMD_SCANSET, CMD_SCANSET
      };
      foreach (directed_bytes[i]) offer_host_byte(directed_bytes[i]);
      drain_replies();

      // Random phases: both sides idling, no idling at all, a dense sender against
      // a long receiver hold-off (fills the queue and raises full), and a mix.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               sender_idle_on   = 1'b1;
               receiver_idle_on = 1'b1;
            end
            1: begin
               sender_idle_on   = 1'b0;
               receiver_idle_on = 1'b0;
            end
            2: begin
               sender_idle_on   = 1'b0;
               receiver_idle_on = 1'b1;
               hold_off_request = 1'b1;
            end
            default: begin
               sender_idle_on   = 1'b1;
               receiver_idle_on = 1'b0;
            end
         endcase
         items_in_phase = 0;
         while (items_in_phase < PHASE_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
               offer_host_byte(CMD_LEDS);
               offer_host_byte(8'($urandom_range(0, 255)));
               items_in_phase += 2;
            end else if (kind < 25) begin
               offer_host_byte(CMD_TYPEMATIC);
               offer_host_byte(8'($urandom_range(0, 255)));
               items_in_phase += 2;
            end else if (kind < 45) begin
               // Scancode-set argument: mostly the two accepted values.
               case ($urandom_range(0, 2))
                  0:       arg = SET_QUERY;
                  1:       arg = SET_NUMBER;
                  default: arg = 8'($urandom_range(0, 255));
               endcase
               offer_host_byte(CMD_SCANSET);
               offer_host_byte(arg);
               items_in_phase += 2;
            end else if (kind < 80) begin
               offer_host_byte(pick_command());
               items_in_phase += 1;
            end else begin
               // Noise: any byte, including a command that leaves an argument pending.
               offer_host_byte(8'($urandom_range(0, 255)));
               items_in_phase += 1;
            end
         end
         drain_replies();
      end

      // Let any stray beat surface before the verdict.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
